// ----- rtl/skt_pkg.sv -----
package skt_pkg;

	// table geometry
	localparam int TABLE_DEPTH   = 64;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int POS_W         = $clog2(TABLE_DEPTH);
	localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

	// fixed field widths of the channels
	localparam int CMD_W      = 2;
	localparam int KEY_HALF_W = 64;
	localparam int PAY_IO_W   = 32;
	localparam int POS_IN_W   = 6;
	localparam int STATUS_W   = 3;
	localparam int POS_OUT_W  = 7;
	localparam int COUNT_W    = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} skt_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 3'd0,
		STAT_DUP    = 3'd1,
		STAT_FULL   = 3'd2,
		STAT_MISS   = 3'd3,
		STAT_BADPOS = 3'd4
	} skt_status_t;

	typedef enum logic {
		SKT_IDLE,
		SKT_APPLY
	} skt_state_t;

	// one table entry as held in a cell
	typedef struct packed {
		logic [KEY_HALF_W-1:0]    key_high;
		logic [KEY_HALF_W-1:0]    key_low;
		logic [PAYLOAD_WIDTH-1:0] payload;
	} skt_entry_t;

	// per-cell update control
	typedef struct packed {
		logic load_new;
		logic take_lo;
		logic take_hi;
	} skt_cell_ctrl_t;

	// per-cell compare result, captured at the command transfer
	typedef struct packed {
		logic lt;
		logic eq;
	} skt_flags_t;

	function automatic logic [PAYLOAD_WIDTH-1:0] pay_to_store(input logic [PAY_IO_W-1:0] v);
		logic [PAYLOAD_WIDTH+PAY_IO_W-1:0] wide;
		wide = {{PAYLOAD_WIDTH{1'b0}}, v};
		return wide[PAYLOAD_WIDTH-1:0];
	endfunction

	function automatic logic [PAY_IO_W-1:0] pay_to_port(input logic [PAYLOAD_WIDTH-1:0] v);
		logic [PAYLOAD_WIDTH+PAY_IO_W-1:0] wide;
		wide = {{PAY_IO_W{1'b0}}, v};
		return wide[PAY_IO_W-1:0];
	endfunction

endpackage

// ----- rtl/skt_if.sv -----
interface skt_cmd_if;
	import skt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      command;
	logic [KEY_HALF_W-1:0] key_high;
	logic [KEY_HALF_W-1:0] key_low;
	logic [PAY_IO_W-1:0]   payload_in;
	logic [POS_IN_W-1:0]   position_in;

	modport source(output valid, command, key_high, key_low, payload_in, position_in,
		input ready);
	modport sink(input valid, command, key_high, key_low, payload_in, position_in,
		output ready);
endinterface

interface skt_res_if;
	import skt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [POS_OUT_W-1:0] position_out;
	logic [PAY_IO_W-1:0]  payload_out;
	logic [COUNT_W-1:0]   entry_count;

	modport source(output valid, status, position_out, payload_out, entry_count,
		input ready);
	modport sink(input valid, status, position_out, payload_out, entry_count,
		output ready);
endinterface

// ----- rtl/skt_cell.sv -----
module skt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmp_en,
	input  logic                          occupied,
	input  logic [skt_pkg::KEY_HALF_W-1:0] search_high,
	input  logic [skt_pkg::KEY_HALF_W-1:0] search_low,
	input  skt_pkg::skt_entry_t           new_entry,
	input  skt_pkg::skt_entry_t           lo_entry,
	input  skt_pkg::skt_entry_t           hi_entry,
	input  skt_pkg::skt_cell_ctrl_t       ctrl,
	output skt_pkg::skt_entry_t           entry,
	output skt_pkg::skt_flags_t           flags
);
	import skt_pkg::*;

	skt_entry_t entry_q;
	skt_flags_t flags_q;
	logic       key_gt;
	logic       key_eq;

	// search key against the held key, high half first
	always_comb begin
		key_eq = (search_high == entry_q.key_high) && (search_low == entry_q.key_low);
		if (search_high != entry_q.key_high) begin
			key_gt = search_high > entry_q.key_high;
		end else begin
			key_gt = search_low > entry_q.key_low;
		end
	end

	// compare flags taken at the command transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cmp_en) begin
			flags_q.lt <= occupied && key_gt;
			flags_q.eq <= occupied && key_eq;
		end
	end

	// entry shift: new key, from the lower neighbour, or from the upper one
	always_ff @(posedge clk) begin
		if (ctrl.load_new) begin
			entry_q <= new_entry;
		end else if (ctrl.take_lo) begin
			entry_q <= lo_entry;
		end else if (ctrl.take_hi) begin
			entry_q <= hi_entry;
		end
	end

	assign entry = entry_q;
	assign flags = flags_q;

endmodule

// ----- rtl/sorted_key_table.sv -----
// sorted_key_table: a table of up to 64 entries kept in ascending key order.
// cmd channel: one transfer per command (insert, find, remove at position),
// carrying a 128-bit key as key_high/key_low, a payload and a position.
// res channel: exactly one result transfer per command, in command order,
// with status, position, found payload and the entry count afterwards.
// The table is a row of cells, one per entry. At the command transfer every
// cell compares the key with its own and keeps the flags; in the apply state
// the boundary cell is found, the result is formed and, for insert or remove,
// the cells from the boundary or the removed position up shift by one place at once.
// The result is registered and offered once the apply state has loaded it.
// cmd.ready is high only while no command is being worked on, so a new
// command is taken only after the last one has been applied.
// If the result register is still held by the receiver, the working command
// waits in the apply state and the table does not change until the result
// slot frees; nothing is lost or repeated.
// Reset empties the table (entry count zero) and clears the result valid flag;
// entries are not cleared, only the count decides which are in use.
module sorted_key_table (
	input  logic          clk,
	input  logic          arst_n,
	skt_cmd_if.sink       cmd,
	skt_res_if.source     res
);
	import skt_pkg::*;

	localparam int CMP_W = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;

	skt_state_t  state_q;
	skt_state_t  state_nxt;

	// command held for the apply cycle
	logic [CMD_W-1:0]         command_q;
	logic [KEY_HALF_W-1:0]    key_high_q;
	logic [KEY_HALF_W-1:0]    key_low_q;
	logic [PAYLOAD_WIDTH-1:0] payload_q;
	logic [POS_IN_W-1:0]      position_q;

	logic [CNT_W-1:0] count_q;

	// result register
	logic                  res_valid_q;
	skt_status_t           status_q;
	logic [POS_OUT_W-1:0]  position_out_q;
	logic [PAY_IO_W-1:0]   payload_out_q;
	logic [COUNT_W-1:0]    entry_count_q;

	logic cmd_xfer;
	logic apply_go;

	skt_entry_t     entries   [TABLE_DEPTH];
	skt_flags_t     flags     [TABLE_DEPTH];
	skt_cell_ctrl_t ctrls     [TABLE_DEPTH];
	logic           occupied  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] lt_vec;
	logic [TABLE_DEPTH-1:0] bnd_vec;

	skt_entry_t new_entry;

	logic [CNT_W-1:0]         lb_pos;
	logic                     hit;
	logic [PAYLOAD_WIDTH-1:0] hit_payload;
	logic                     full;
	logic                     remove_ok;
	logic                     insert_ok;
	logic [CMP_W-1:0]         pos_ext;
	logic [CMP_W-1:0]         count_ext;

	skt_status_t              status_nxt;
	logic [CNT_W-1:0]         pos_nxt;
	logic [PAY_IO_W-1:0]      pay_nxt;
	logic [CNT_W-1:0]         count_nxt;

	assign cmd_xfer = cmd.valid && cmd.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			SKT_IDLE: begin
				if (cmd.valid) begin
					state_nxt = SKT_APPLY;
				end
			end
			SKT_APPLY: begin
				if (!res_valid_q || res.ready) begin
					state_nxt = SKT_IDLE;
				end
			end
			default: state_nxt = SKT_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd.ready = 1'b0;
		apply_go  = 1'b0;
		case (state_q)
			SKT_IDLE:  cmd.ready = 1'b1;
			SKT_APPLY: apply_go  = !res_valid_q || res.ready;
			default: begin
				cmd.ready = 1'b0;
				apply_go  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SKT_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			command_q  <= cmd.command;
			key_high_q <= cmd.key_high;
			key_low_q  <= cmd.key_low;
			payload_q  <= pay_to_store(cmd.payload_in);
			position_q <= cmd.position_in;
		end
	end

	assign new_entry.key_high = key_high_q;
	assign new_entry.key_low  = key_low_q;
	assign new_entry.payload  = payload_q;

	// boundary cell: first one whose key is not below the search key
	always_comb begin
		lb_pos      = '0;
		hit         = 1'b0;
		hit_payload = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (bnd_vec[i]) begin
				lb_pos      = lb_pos | CNT_W'(i);
				hit         = hit | flags[i].eq;
				hit_payload = hit_payload | (flags[i].eq ? entries[i].payload : '0);
			end
		end
		if (lt_vec[TABLE_DEPTH-1]) begin
			lb_pos = CNT_W'(TABLE_DEPTH);
		end
	end

	assign full      = count_q == CNT_W'(TABLE_DEPTH);
	assign pos_ext   = CMP_W'(position_q);
	assign count_ext = CMP_W'(count_q);
	assign remove_ok = (command_q == CMD_REMOVE) && (pos_ext < count_ext);
	assign insert_ok = (command_q == CMD_INSERT) && !hit && !full;

	// result and new count
	always_comb begin
		status_nxt = STAT_BADPOS;
		pos_nxt    = '0;
		pay_nxt    = '0;
		count_nxt  = count_q;
		case (skt_cmd_t'(command_q))
			CMD_INSERT: begin
				pos_nxt = lb_pos;
				if (hit) begin
					status_nxt = STAT_DUP;
				end else if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					status_nxt = STAT_OK;
					count_nxt  = count_q + CNT_W'(1);
				end
			end
			CMD_FIND: begin
				pos_nxt = lb_pos;
				if (hit) begin
					status_nxt = STAT_OK;
					pay_nxt    = pay_to_port(hit_payload);
				end else begin
					status_nxt = STAT_MISS;
				end
			end
			CMD_REMOVE: begin
				pos_nxt = CNT_W'(position_q);
				if (remove_ok) begin
					status_nxt = STAT_OK;
					count_nxt  = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_nxt = STAT_BADPOS;
				pos_nxt    = '0;
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (apply_go) begin
			count_q <= count_nxt;
		end
	end

	// result register, freed by the result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (apply_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			status_q       <= status_nxt;
			position_out_q <= POS_OUT_W'(pos_nxt);
			payload_out_q  <= pay_nxt;
			entry_count_q  <= COUNT_W'(count_nxt);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = status_q;
	assign res.position_out = position_out_q;
	assign res.payload_out  = payload_out_q;
	assign res.entry_count  = entry_count_q;

	// row of cells with their local shift control
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		skt_entry_t lo_nb;
		skt_entry_t hi_nb;

		assign occupied[i] = CNT_W'(i) < count_q;
		assign lt_vec[i]   = flags[i].lt;

		if (i == 0) begin : g_first
			assign bnd_vec[i] = !flags[i].lt;
			assign lo_nb      = entries[i];
		end else begin : g_rest
			assign bnd_vec[i] = !flags[i].lt && flags[i-1].lt;
			assign lo_nb      = entries[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign hi_nb = entries[i];
		end else begin : g_inner
			assign hi_nb = entries[i+1];
		end

		assign ctrls[i].load_new = apply_go && insert_ok && bnd_vec[i];
		assign ctrls[i].take_lo  = apply_go && insert_ok && !flags[i].lt && !bnd_vec[i];
		assign ctrls[i].take_hi  = apply_go && remove_ok && (CMP_W'(i) >= pos_ext);

		skt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmp_en      (cmd_xfer),
			.occupied    (occupied[i]),
			.search_high (cmd.key_high),
			.search_low  (cmd.key_low),
			.new_entry   (new_entry),
			.lo_entry    (lo_nb),
			.hi_entry    (hi_nb),
			.ctrl        (ctrls[i]),
			.entry       (entries[i]),
			.flags       (flags[i])
		);
	end

endmodule

// ----- bench/tb_sorted_key_table.sv -----
`timescale 1ns / 100ps

module tb_sorted_key_table;
	import skt_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 1350;
	localparam int PRINT_CAP    = 50;

	// one command as offered on the command channel
	typedef struct {
		skt_cmd_t              command;
		logic [KEY_HALF_W-1:0] key_high;
		logic [KEY_HALF_W-1:0] key_low;
		logic [PAY_IO_W-1:0]   payload;
		logic [POS_IN_W-1:0]   position;
		bit                    drain_first;
	} table_cmd_t;

	// one expected result transfer
	typedef struct {
		skt_status_t          status;
		logic [POS_OUT_W-1:0] position;
		logic [PAY_IO_W-1:0]  payload;
		logic [COUNT_W-1:0]   count;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;

	skt_cmd_if cmd_ch ();
	skt_res_if res_ch ();

	sorted_key_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	always #5 clk = ~clk;

	// shadow copy of the sorted table
	logic [2*KEY_HALF_W-1:0] table_keys [TABLE_DEPTH];
	logic [PAY_IO_W-1:0]     table_pays [TABLE_DEPTH];
	int                      table_used = 0;

	table_cmd_t        pending_cmds [$];
	table_result_t     expected_results [$];
	logic [2*KEY_HALF_W-1:0] key_pool [$];

	int sent_n       = 0;
	int taken_n      = 0;
	int results_seen = 0;
	int mismatch_n   = 0;
	int cycle_n      = 0;

	// applies one command to the shadow table and returns its result
	function automatic table_result_t table_apply(input table_cmd_t c);
		table_result_t           r;
		logic [2*KEY_HALF_W-1:0] k;
		int                      lb;
		int                      i;
		bit                      hit;
		k = {c.key_high, c.key_low};
		r.status = STAT_BADPOS;
		r.position = '0;
		r.payload = '0;
		case (c.command)
			CMD_INSERT, CMD_FIND: begin
				lb = 0;
				for (i = 0; i < table_used; i++)
					if (k > table_keys[i])
						lb++;
				hit = (lb < table_used) && (table_keys[lb] == k);
				r.position = POS_OUT_W'(lb);
				if (c.command == CMD_FIND) begin
					if (hit) begin
						r.status = STAT_OK;
						r.payload = table_pays[lb];
					end else begin
						r.status = STAT_MISS;
					end
				end else if (hit) begin
					r.status = STAT_DUP;
				end else if (table_used >= TABLE_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					// open a slot at the lower bound
					for (i = table_used; i > lb; i--) begin
						table_keys[i] = table_keys[i-1];
						table_pays[i] = table_pays[i-1];
					end
					table_keys[lb] = k;
					table_pays[lb] = c.payload;
					table_used++;
					r.status = STAT_OK;
				end
			end
			CMD_REMOVE: begin
				r.position = POS_OUT_W'(c.position);
				if (int'(c.position) < table_used) begin
					// close the gap left by the removed entry
					for (i = int'(c.position); i + 1 < table_used; i++) begin
						table_keys[i] = table_keys[i+1];
						table_pays[i] = table_pays[i+1];
					end
					table_used--;
					r.status = STAT_OK;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(table_used);
		return r;
	endfunction

	function automatic logic [2*KEY_HALF_W-1:0] fresh_key();
		logic [2*KEY_HALF_W-1:0] k;
		k = {$urandom, $urandom, $urandom, $urandom};
		// sometimes share the upper half so the lower half decides the order
		if (key_pool.size() > 0 && $urandom_range(0, 2) == 0)
			k[2*KEY_HALF_W-1:KEY_HALF_W] =
				key_pool[$urandom_range(0, key_pool.size()-1)][2*KEY_HALF_W-1:KEY_HALF_W];
		return k;
	endfunction

	task automatic queue_cmd(input skt_cmd_t op, input logic [2*KEY_HALF_W-1:0] k,
			input logic [POS_IN_W-1:0] pos, input bit drain);
		table_cmd_t c;
		c.command = op;
		c.key_high = k[2*KEY_HALF_W-1:KEY_HALF_W];
		c.key_low = k[KEY_HALF_W-1:0];
		c.payload = $urandom;
		c.position = pos;
		c.drain_first = drain;
		pending_cmds.push_back(c);
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_n < PRINT_CAP)
			$display("mismatch in %s at result %0d: got %0h, want %0h",
				what, results_seen, got, want);
		mismatch_n++;
	endtask

	// command driver: bursts with random gaps, optional wait for an empty pipeline
	int         burst_left = 0;
	int         gap_left   = 0;
	table_cmd_t drive_item;

	always @(negedge clk) begin
		if (arst_n && sent_n == taken_n) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_ch.valid <= 1'b0;
			end else if (pending_cmds.size() == 0 ||
					(pending_cmds[0].drain_first && expected_results.size() != 0)) begin
				cmd_ch.valid <= 1'b0;
			end else begin
				drive_item = pending_cmds.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.command <= drive_item.command;
				cmd_ch.key_high <= drive_item.key_high;
				cmd_ch.key_low <= drive_item.key_low;
				cmd_ch.payload_in <= drive_item.payload;
				cmd_ch.position_in <= drive_item.position;
				sent_n++;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// result receiver: stall modes of its own, plus one long hold-off
	int  rx_mode   = 0;
	int  mode_left = 0;
	int  rx_phase  = 0;
	int  hold_left = 0;
	bit  held_once = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!held_once && results_seen >= 200) begin
				held_once = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 200);
				end
				mode_left--;
				rx_phase++;
				case (rx_mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 9) < 7);
					2: res_ch.ready <= ($urandom_range(0, 9) < 3);
					default: res_ch.ready <= (rx_phase % 5 != 0);
				endcase
			end
		end
	end

	// monitor: predict at each command transfer, check each result transfer
	table_cmd_t    seen_cmd;
	table_result_t want;

	always @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			seen_cmd.command = skt_cmd_t'(cmd_ch.command);
			seen_cmd.key_high = cmd_ch.key_high;
			seen_cmd.key_low = cmd_ch.key_low;
			seen_cmd.payload = cmd_ch.payload_in;
			seen_cmd.position = cmd_ch.position_in;
			seen_cmd.drain_first = 0;
			expected_results.push_back(table_apply(seen_cmd));
			taken_n++;
		end
		if (res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("unexpected result, status", 64'(res_ch.status), '0);
			end else begin
				want = expected_results.pop_front();
				if (res_ch.status !== want.status)
					flag_mismatch("status", 64'(res_ch.status), 64'(want.status));
				if (res_ch.position_out !== want.position)
					flag_mismatch("position_out", 64'(res_ch.position_out),
						64'(want.position));
				if (res_ch.payload_out !== want.payload)
					flag_mismatch("payload_out", 64'(res_ch.payload_out),
						64'(want.payload));
				if (res_ch.entry_count !== want.count)
					flag_mismatch("entry_count", 64'(res_ch.entry_count), 64'(want.count));
			end
			results_seen++;
		end
	end

	// watchdog
	initial begin
		while (cycle_n < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_n++;
		end
		$display("[sorted_key_table] ERROR");
		$finish;
	end

	// stimulus, reset and end of run
	logic [2*KEY_HALF_W-1:0] kk;
	logic [2*KEY_HALF_W-1:0] k_ones;
	skt_cmd_t                op;
	logic [POS_IN_W-1:0]     pos;
	int                      random_n;
	int                      phase;
	int                      len;
	int                      n;
	int                      r;
	bit                      first;
	bit                      drain;

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_INSERT;
		cmd_ch.key_high = '0;
		cmd_ch.key_low = '0;
		cmd_ch.payload_in = '0;
		cmd_ch.position_in = '0;
		res_ch.ready = 1'b0;
		k_ones = '1;

		// key pool with edge keys and keys sharing an upper half
		key_pool.push_back('0);
		key_pool.push_back(k_ones);
		key_pool.push_back({{KEY_HALF_W{1'b0}}, {KEY_HALF_W{1'b1}}});
		key_pool.push_back({{KEY_HALF_W{1'b1}}, {KEY_HALF_W{1'b0}}});
		key_pool.push_back({64'd1, 64'd0});
		for (n = 0; n < 60; n++)
			key_pool.push_back(fresh_key());

		// directed: empty table, extremes, duplicates, hits, misses, bad positions
		queue_cmd(CMD_FIND, '0, 6'd5, 0);
		queue_cmd(CMD_REMOVE, '0, 6'd0, 0);
		queue_cmd(CMD_NOP, k_ones, 6'd63, 0);
		queue_cmd(CMD_INSERT, k_ones, 6'd0, 0);
		queue_cmd(CMD_INSERT, '0, 6'd63, 0);
		queue_cmd(CMD_INSERT, {{KEY_HALF_W{1'b0}}, {KEY_HALF_W{1'b1}}}, 6'd0, 0);
		queue_cmd(CMD_INSERT, {64'd1, 64'd0}, 6'd0, 0);
		queue_cmd(CMD_INSERT, k_ones, 6'd0, 0);
		queue_cmd(CMD_FIND, {64'd1, 64'd0}, 6'd0, 0);
		queue_cmd(CMD_FIND, {64'd0, 64'h8000_0000_0000_0000}, 6'd0, 0);
		queue_cmd(CMD_FIND, k_ones, 6'd0, 0);
		queue_cmd(CMD_FIND, {64'd0, k_ones[KEY_HALF_W-1:0]}, 6'd0, 0);
		queue_cmd(CMD_REMOVE, '0, 6'd63, 0);
		queue_cmd(CMD_REMOVE, '0, 6'd4, 0);
		queue_cmd(CMD_REMOVE, '0, 6'd0, 0);
		queue_cmd(CMD_REMOVE, '0, 6'd2, 0);
		queue_cmd(CMD_FIND, '0, 6'd0, 0);
		queue_cmd(CMD_NOP, '0, 6'd0, 0);
		queue_cmd(CMD_INSERT, {{KEY_HALF_W{1'b1}}, {KEY_HALF_W{1'b0}}}, 6'd0, 0);
		queue_cmd(CMD_INSERT, {64'd1, 64'd1}, 6'd0, 0);
		queue_cmd(CMD_FIND, {{KEY_HALF_W{1'b1}}, {KEY_HALF_W{1'b0}}}, 6'd0, 0);
		queue_cmd(CMD_REMOVE, '0, 6'd1, 0);
		queue_cmd(CMD_FIND, {64'd1, 64'd1}, 6'd0, 0);

		// random phases: fill (the first one is long and mostly inserts, so it can overfill the table), mixed, drain
		random_n = 0;
		first = 1;
		while (random_n < RANDOM_ITEMS) begin
			phase = first ? 0 : $urandom_range(0, 3);
			len = first ? 80 : $urandom_range(20, 90);
			drain = first || ($urandom_range(0, 4) == 0);
			for (n = 0; n < len; n++) begin
				r = $urandom_range(0, 99);
				kk = key_pool[$urandom_range(0, key_pool.size()-1)];
				case (phase)
					0: begin
						if (r < 80) begin
							op = CMD_INSERT;
							kk = fresh_key();
							key_pool.push_back(kk);
						end else begin
							op = CMD_FIND;
						end
					end
					3: op = (r < 65) ? CMD_REMOVE : CMD_FIND;
					default: begin
						if (r < 40)
							op = CMD_INSERT;
						else if (r < 70)
							op = CMD_FIND;
						else if (r < 95)
							op = CMD_REMOVE;
						else
							op = CMD_NOP;
						if (r >= 40 && r < 45)
							kk = fresh_key();
					end
				endcase
				if (op == CMD_REMOVE && $urandom_range(0, 2) != 0)
					pos = POS_IN_W'($urandom_range(0, 15));
				else
					pos = POS_IN_W'($urandom_range(0, 63));
				queue_cmd(op, kk, pos, drain && n == 0);
				random_n++;
			end
			first = 0;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for every command to go out and every result to come back
		while (pending_cmds.size() != 0 || sent_n != taken_n)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_n == 0)
			$display("[sorted_key_table] OK");
		else
			$display("[sorted_key_table] ERROR");
		$finish;
	end

endmodule
